>>> sv/sfd_pkg.sv
// shared types, constants and the crc update for the serial frame deframer
`default_nettype none

package sfd_pkg;

    // header, tail and frame type codes
    localparam logic [7:0] HDR_FIRST   = 8'hAA;
    localparam logic [7:0] HDR_SECOND  = 8'h55;
    localparam logic [7:0] TAIL_FIRST  = 8'h0D;
    localparam logic [7:0] TAIL_SECOND = 8'h0A;
    localparam logic [7:0] TYPE_PERC   = 8'h10;
    localparam logic [7:0] TYPE_POSE   = 8'h11;

    // frame lengths and byte positions
    localparam logic [5:0] LEN_PERC    = 6'd37;
    localparam logic [5:0] LEN_POSE    = 6'd29;
    localparam logic [5:0] POS_TYPE    = 6'd2;
    localparam int         FIELD_FIRST = 3;
    localparam int         FIELD_LAST  = 32;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        PH_HUNT0 = 2'd0,
        PH_HUNT1 = 2'd1,
        PH_FRAME = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_PERC_OK  = 2'd0,
        ST_POSE_OK  = 2'd1,
        ST_BAD_TAIL = 2'd2,
        ST_BAD_CRC  = 2'd3
    } status_t;

    typedef struct packed {
        status_t     frame_status;
        logic [7:0]  sequence_res;
        logic [7:0]  flags;
        logic [31:0] timestamp;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic [31:0] word3;
        logic [31:0] word4;
        logic [31:0] word5;
        logic [31:0] good_count;
        logic [31:0] bad_count;
    } result_t;

    // one byte through the msb-first crc, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/serial_frame_deframer_crc16.sv
// top level of the serial frame deframer with crc-16 check
// a frame's last byte waits in the input register until the result register can take the
// finished frame; out_valid rises when the result register is loaded
// throughput: one byte per cycle while no finished frame waits on a full result register;
// the byte-wide crc update and field capture sit between the input register and the result register
// reset: asynchronous active low; hunt restarts, crc 0xffff, counters zero
`default_nettype none

module serial_frame_deframer_crc16 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       frame_status,
    output logic [7:0]       sequence_res,
    output logic [7:0]       flags,
    output logic [31:0]      timestamp,
    output logic [31:0]      word0,
    output logic [31:0]      word1,
    output logic [31:0]      word2,
    output logic [31:0]      word3,
    output logic [31:0]      word4,
    output logic [31:0]      word5,
    output logic [31:0]      good_count,
    output logic [31:0]      bad_count
);

    // input register, one byte deep
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // parser handshake
    logic             step;
    logic             res_valid;
    logic             out_free;
    sfd_pkg::result_t res;
    sfd_pkg::result_t res_q;

    // result register can take a new frame when empty or being drained
    assign out_free = !out_valid || out_ready;
    // a byte that finishes no frame never waits on the output side
    assign step     = in_valid_reg && (out_free || !res_valid);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
    end

    sfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sfd_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (step && res_valid),
        .res_in  (res),
        .take    (out_ready),
        .valid   (out_valid),
        .res_out (res_q)
    );

    // unpack the result onto the field ports
    assign frame_status = res_q.frame_status;
    assign sequence_res = res_q.sequence_res;
    assign flags        = res_q.flags;
    assign timestamp    = res_q.timestamp;
    assign word0        = res_q.word0;
    assign word1        = res_q.word1;
    assign word2        = res_q.word2;
    assign word3        = res_q.word3;
    assign word4        = res_q.word4;
    assign word5        = res_q.word5;
    assign good_count   = res_q.good_count;
    assign bad_count    = res_q.bad_count;

`ifndef SYNTHESIS
    // an empty input register always takes a transfer
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input register empty but not ready");

    // a finished frame shows up as a result in the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res_valid) |=> out_valid)
        else $error("finished frame did not reach the result register");

    // a stalled byte stays in the input register unchanged
    a_byte_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled byte lost or changed");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(step && res_valid))
        else $error("result register overwritten while waiting");
`endif

endmodule

`default_nettype wire

>>> sv/sfd_parser.sv
// frame hunt state machine, crc, field capture and result assembly
`default_nettype none

module sfd_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    output logic                 res_valid,
    output sfd_pkg::result_t     res
);

    sfd_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  pos_reg, pos_next;
    logic        long_reg, long_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    // frame bytes 3..32, each read at its own place
    logic [7:0] frame_bytes_reg [sfd_pkg::FIELD_FIRST:sfd_pkg::FIELD_LAST];
    // last three frame bytes, index 0 newest
    logic [7:0] hist_reg [0:2];

    logic       at_type;
    logic       type_ok;
    logic       long_now;
    logic       in_store;
    logic       is_last;
    logic       frame_ok;
    logic       frame_good;
    logic [5:0] crc_limit;
    sfd_pkg::status_t status;

    assign at_type  = (pos_reg == sfd_pkg::POS_TYPE);
    assign type_ok  = rx_byte inside {sfd_pkg::TYPE_PERC, sfd_pkg::TYPE_POSE};
    assign long_now = at_type ? (rx_byte == sfd_pkg::TYPE_PERC) : long_reg;
    assign in_store = (pos_reg < sfd_pkg::LEN_PERC);
    assign is_last  = long_now ? (pos_reg == sfd_pkg::LEN_PERC - 6'd1)
                               : (pos_reg == sfd_pkg::LEN_POSE - 6'd1);
    assign crc_limit = long_now ? (sfd_pkg::LEN_PERC - 6'd4) : (sfd_pkg::LEN_POSE - 6'd4);
    assign frame_ok = (phase_reg == sfd_pkg::PH_FRAME) && in_store && !(at_type && !type_ok);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            sfd_pkg::PH_HUNT0:
            begin
                if (rx_byte == sfd_pkg::HDR_FIRST)
                    phase_next = sfd_pkg::PH_HUNT1;
            end
            sfd_pkg::PH_HUNT1:
            begin
                if (rx_byte == sfd_pkg::HDR_SECOND)
                    phase_next = sfd_pkg::PH_FRAME;
                else if (rx_byte != sfd_pkg::HDR_FIRST)
                    phase_next = sfd_pkg::PH_HUNT0;
            end
            sfd_pkg::PH_FRAME:
            begin
                if (!frame_ok || is_last)
                    phase_next = sfd_pkg::PH_HUNT0;
            end
            default:
                phase_next = sfd_pkg::PH_HUNT0;
        endcase
    end

    // status of a finished frame, tail before crc
    always_comb
    begin
        if (hist_reg[0] != sfd_pkg::TAIL_FIRST || rx_byte != sfd_pkg::TAIL_SECOND)
            status = sfd_pkg::ST_BAD_TAIL;
        else if ({hist_reg[1], hist_reg[2]} != crc_reg)
            status = sfd_pkg::ST_BAD_CRC;
        else if (long_reg)
            status = sfd_pkg::ST_PERC_OK;
        else
            status = sfd_pkg::ST_POSE_OK;
    end

    assign frame_good = (status == sfd_pkg::ST_PERC_OK) || (status == sfd_pkg::ST_POSE_OK);

    // datapath and outputs
    always_comb
    begin
        pos_next  = pos_reg;
        long_next = long_reg;
        crc_next  = crc_reg;
        good_next = good_reg;
        bad_next  = bad_reg;
        res_valid = 1'b0;
        case (phase_reg)
            sfd_pkg::PH_HUNT0:
            begin
            end
            sfd_pkg::PH_HUNT1:
            begin
                if (rx_byte == sfd_pkg::HDR_SECOND)
                begin
                    pos_next = sfd_pkg::POS_TYPE;
                    crc_next = sfd_pkg::CRC_INIT;
                end
                else if (rx_byte != sfd_pkg::HDR_FIRST)
                begin
                    pos_next  = 6'd0;
                    long_next = 1'b0;
                end
            end
            sfd_pkg::PH_FRAME:
            begin
                if (!frame_ok)
                begin
                    pos_next  = 6'd0;
                    long_next = 1'b0;
                end
                else
                begin
                    long_next = long_now;
                    if (pos_reg < crc_limit)
                        crc_next = sfd_pkg::crc_byte(crc_reg, rx_byte);
                    pos_next = pos_reg + 6'd1;
                    if (is_last)
                    begin
                        res_valid = 1'b1;
                        pos_next  = 6'd0;
                        long_next = 1'b0;
                        if (frame_good)
                            good_next = good_reg + 32'd1;
                        else
                            bad_next = bad_reg + 32'd1;
                    end
                end
            end
            default:
            begin
                pos_next  = 6'd0;
                long_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.frame_status = status;
        res.sequence_res = frame_bytes_reg[3];
        res.flags        = frame_bytes_reg[4];
        res.timestamp    = {frame_bytes_reg[8], frame_bytes_reg[7],
                            frame_bytes_reg[6], frame_bytes_reg[5]};
        res.word0        = {frame_bytes_reg[12], frame_bytes_reg[11],
                            frame_bytes_reg[10], frame_bytes_reg[9]};
        res.word1        = {frame_bytes_reg[16], frame_bytes_reg[15],
                            frame_bytes_reg[14], frame_bytes_reg[13]};
        res.word2        = {frame_bytes_reg[20], frame_bytes_reg[19],
                            frame_bytes_reg[18], frame_bytes_reg[17]};
        res.word3        = {frame_bytes_reg[24], frame_bytes_reg[23],
                            frame_bytes_reg[22], frame_bytes_reg[21]};
        res.word4        = long_reg ? {frame_bytes_reg[28], frame_bytes_reg[27],
                                       frame_bytes_reg[26], frame_bytes_reg[25]} : 32'd0;
        res.word5        = long_reg ? {frame_bytes_reg[32], frame_bytes_reg[31],
                                       frame_bytes_reg[30], frame_bytes_reg[29]} : 32'd0;
        res.good_count   = good_next;
        res.bad_count    = bad_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfd_pkg::PH_HUNT0;
            pos_reg   <= 6'd0;
            long_reg  <= 1'b0;
            crc_reg   <= sfd_pkg::CRC_INIT;
            good_reg  <= 32'd0;
            bad_reg   <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            long_reg  <= long_next;
            crc_reg   <= crc_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
        end
    end

    // byte capture, no reset
    always_ff @(posedge clk)
    begin
        if (step && frame_ok)
        begin
            hist_reg[0] <= rx_byte;
            hist_reg[1] <= hist_reg[0];
            hist_reg[2] <= hist_reg[1];
            for (int i = sfd_pkg::FIELD_FIRST; i <= sfd_pkg::FIELD_LAST; i++)
            begin
                if (pos_reg == 6'(i))
                    frame_bytes_reg[i] <= rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/sfd_out_stage.sv
// result register holding one finished frame until transfer
`default_nettype none

module sfd_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire sfd_pkg::result_t res_in,
    input  wire logic             take,
    output logic                  valid,
    output sfd_pkg::result_t      res_out
);

    logic             valid_reg;
    sfd_pkg::result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (take)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

`default_nettype wire

>>> tb/serial_frame_deframer_crc16_test.sv
// testbench for the serial frame deframer: framed byte streams in, predicted frame results out
module serial_frame_deframer_crc16_test;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transfer before the run is declared hung
    localparam int unsigned STALL_LIMIT = 5000;
    // quiet cycles after the last result, to catch a stray one
    localparam int unsigned TAIL_CYCLES = 8;
    localparam int unsigned MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        KIND_GOOD,
        KIND_BAD_TAIL,
        KIND_BAD_CRC,
        KIND_BAD_TYPE,
        KIND_CUT
    } frame_kind_t;

    // clock, reset and the block's ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  frame_status;
    logic [7:0]  sequence_res;
    logic [7:0]  flags;
    logic [31:0] timestamp;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;
    logic [31:0] good_count;
    logic [31:0] bad_count;

    // predictor state, kept apart from the block
    sfd_pkg::phase_t hunt_phase;
    logic [5:0]  next_pos;
    logic        is_long;
    logic [15:0] crc_acc;
    logic [7:0]  captured [0:36];
    logic [31:0] good_seen;
    logic [31:0] bad_seen;

    // frame results still owed by the block, oldest first
    sfd_pkg::result_t frames_due [$];

    // handshake pacing shared by the sender task and the result process
    bit          idle_on       = 1'b1;
    int unsigned pending_gap   = 0;
    bit          valid_held    = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned stall_left    = 0;

    // bookkeeping
    int unsigned mismatches       = 0;
    int unsigned bytes_sent       = 0;
    int unsigned frame_bytes_sent = 0;
    int unsigned frames_checked   = 0;
    int unsigned good_checked     = 0;
    int unsigned bad_checked      = 0;
    int unsigned quiet_cycles     = 0;

    serial_frame_deframer_crc16 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_status (frame_status),
        .sequence_res (sequence_res),
        .flags        (flags),
        .timestamp    (timestamp),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .word4        (word4),
        .word5        (word5),
        .good_count   (good_count),
        .bad_count    (bad_count)
    );

    // 10 ns clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // msb-first crc-16/ccitt-false, one data bit folded in per step
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ d[i];
            r  = {r[14:0], 1'b0} ^ (fb ? sfd_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // little-endian word from the captured frame bytes
    function automatic logic [31:0] captured_word(input int at);
        return {captured[at + 3], captured[at + 2], captured[at + 1], captured[at]};
    endfunction

    task automatic restart_hunt();
        hunt_phase = sfd_pkg::PH_HUNT0;
        next_pos   = 6'd0;
        is_long    = 1'b0;
    endtask

    task automatic deframer_reset();
        restart_hunt();
        crc_acc   = sfd_pkg::CRC_INIT;
        good_seen = 32'd0;
        bad_seen  = 32'd0;
    endtask

    // closes a frame: tail first, then crc, then counters and the result
    task automatic close_frame(input logic [5:0] len);
        sfd_pkg::result_t r;
        logic [15:0]      rx_crc;
        sfd_pkg::status_t st;
        rx_crc = {captured[len - 3], captured[len - 4]};
        if (captured[len - 2] != sfd_pkg::TAIL_FIRST ||
            captured[len - 1] != sfd_pkg::TAIL_SECOND)
            st = sfd_pkg::ST_BAD_TAIL;
        else if (rx_crc != crc_acc)
            st = sfd_pkg::ST_BAD_CRC;
        else
            st = is_long ? sfd_pkg::ST_PERC_OK : sfd_pkg::ST_POSE_OK;
        if (st == sfd_pkg::ST_PERC_OK || st == sfd_pkg::ST_POSE_OK)
            good_seen = good_seen + 32'd1;
        else
            bad_seen = bad_seen + 32'd1;
        r.frame_status = st;
        r.sequence_res = captured[3];
        r.flags        = captured[4];
        r.timestamp    = captured_word(5);
        r.word0        = captured_word(9);
        r.word1        = captured_word(13);
        r.word2        = captured_word(17);
        r.word3        = captured_word(21);
        r.word4        = is_long ? captured_word(25) : 32'd0;
        r.word5        = is_long ? captured_word(29) : 32'd0;
        r.good_count   = good_seen;
        r.bad_count    = bad_seen;
        frames_due.push_back(r);
    endtask

    // predicts the effect of one accepted byte
    task automatic deframe_byte(input logic [7:0] b);
        logic [5:0] len;
        case (hunt_phase)
            sfd_pkg::PH_HUNT0:
            begin
                if (b == sfd_pkg::HDR_FIRST)
                    hunt_phase = sfd_pkg::PH_HUNT1;
            end
            sfd_pkg::PH_HUNT1:
            begin
                if (b == sfd_pkg::HDR_SECOND)
                begin
                    hunt_phase = sfd_pkg::PH_FRAME;
                    next_pos   = sfd_pkg::POS_TYPE;
                    crc_acc    = sfd_pkg::CRC_INIT;
                end
                else if (b != sfd_pkg::HDR_FIRST)
                    restart_hunt();
            end
            sfd_pkg::PH_FRAME:
            begin
                if (next_pos >= sfd_pkg::LEN_PERC)
                begin
                    restart_hunt();
                    return;
                end
                captured[next_pos] = b;
                if (next_pos == sfd_pkg::POS_TYPE)
                begin
                    if (b == sfd_pkg::TYPE_PERC)
                        is_long = 1'b1;
                    else if (b == sfd_pkg::TYPE_POSE)
                        is_long = 1'b0;
                    else
                    begin
                        restart_hunt();
                        return;
                    end
                end
                len = is_long ? sfd_pkg::LEN_PERC : sfd_pkg::LEN_POSE;
                if (next_pos < len - 6'd4)
                    crc_acc = crc16_step(crc_acc, b);
                next_pos = next_pos + 6'd1;
                if (next_pos >= len)
                begin
                    close_frame(len);
                    restart_hunt();
                end
            end
            default:
                restart_hunt();
        endcase
    endtask

    task automatic report_issue(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_issue($sformatf("frame %0d %s: got %h, expected %h",
                                   frames_checked, name, got, want));
    endtask

    // one result transfer against the oldest frame still owed
    task automatic check_frame_result();
        sfd_pkg::result_t want;
        if (frames_due.size() == 0)
        begin
            report_issue($sformatf("result with no frame due, status %0d seq %h",
                                   frame_status, sequence_res));
            return;
        end
        want = frames_due.pop_front();
        compare_field("frame_status", 32'(frame_status), 32'(want.frame_status));
        compare_field("sequence_res", 32'(sequence_res), 32'(want.sequence_res));
        compare_field("flags",        32'(flags),        32'(want.flags));
        compare_field("timestamp",    timestamp,         want.timestamp);
        compare_field("word0",        word0,             want.word0);
        compare_field("word1",        word1,             want.word1);
        compare_field("word2",        word2,             want.word2);
        compare_field("word3",        word3,             want.word3);
        compare_field("word4",        word4,             want.word4);
        compare_field("word5",        word5,             want.word5);
        compare_field("good_count",   good_count,        want.good_count);
        compare_field("bad_count",    bad_count,         want.bad_count);
        if (want.frame_status == sfd_pkg::ST_PERC_OK ||
            want.frame_status == sfd_pkg::ST_POSE_OK)
            good_checked++;
        else
            bad_checked++;
        frames_checked++;
    endtask

    // receiving side: checks each result transfer and paces out_ready,
    // with a per-result stall and an optional long hold-off
    initial
    begin
        stall_left = $urandom_range(0, 17);
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_frame_result();
                stall_left = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog: cycles in which neither channel has a transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("serial_frame_deframer_crc16_test: FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // sends one byte: waits out the gap drawn after the previous byte, then
    // holds valid until the transfer; valid stays high when the next gap is zero
    task automatic send_byte(input logic [7:0] b);
        repeat (pending_gap) @(posedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(b);
        bytes_sent++;
        pending_gap = idle_on ? $urandom_range(0, 17) : 0;
        valid_held  = (pending_gap == 0);
        if (!valid_held)
            in_valid <= 1'b0;
    endtask

    // drops valid and waits until every owed result has been transferred
    task automatic wait_for_drain();
        if (valid_held)
            in_valid <= 1'b0;
        valid_held  = 1'b0;
        pending_gap = 0;
        do
            @(posedge clk);
        while (frames_due.size() != 0);
    endtask

    // builds a frame of the given kind and sends it; payload either random
    // or one fill value throughout
    task automatic send_frame(input frame_kind_t kind, input bit perc,
                              input bit use_fill, input logic [7:0] fill);
        logic [7:0]  f [0:36];
        logic [15:0] c;
        int          len;
        int          n;
        int          idx;
        logic [7:0]  t;
        len  = perc ? 37 : 29;
        f[0] = sfd_pkg::HDR_FIRST;
        f[1] = sfd_pkg::HDR_SECOND;
        f[2] = perc ? sfd_pkg::TYPE_PERC : sfd_pkg::TYPE_POSE;
        for (int i = 3; i < len - 4; i++)
            f[i] = use_fill ? fill : 8'($urandom);
        c = sfd_pkg::CRC_INIT;
        for (int i = 2; i < len - 4; i++)
            c = crc16_step(c, f[i]);
        f[len - 4] = c[7:0];
        f[len - 3] = c[15:8];
        f[len - 2] = sfd_pkg::TAIL_FIRST;
        f[len - 1] = sfd_pkg::TAIL_SECOND;
        n = len;
        case (kind)
            KIND_BAD_TAIL:
            begin
                idx    = len - 2 + $urandom_range(0, 1);
                f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
                // a broken crc as well must still read as a bad tail
                if ($urandom_range(0, 1))
                    f[len - 4] = f[len - 4] ^ 8'($urandom_range(1, 255));
            end
            KIND_BAD_CRC:
            begin
                idx    = len - 4 + $urandom_range(0, 1);
                f[idx] = f[idx] ^ 8'($urandom_range(1, 255));
            end
            KIND_BAD_TYPE:
            begin
                do
                    t = 8'($urandom);
                while (t == sfd_pkg::TYPE_PERC || t == sfd_pkg::TYPE_POSE);
                f[2] = t;
            end
            KIND_CUT:
                n = $urandom_range(3, len - 1);
            default:
            begin
            end
        endcase
        for (int i = 0; i < n; i++)
            send_byte(f[i]);
        frame_bytes_sent += n;
    endtask

    // line noise, leaning towards header bytes
    task automatic send_noise(input int count);
        int unsigned pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 7);
            if (pick < 2)
                send_byte(sfd_pkg::HDR_FIRST);
            else if (pick == 2)
                send_byte(sfd_pkg::HDR_SECOND);
            else
                send_byte(8'($urandom));
        end
    endtask

    // extreme payloads back to back with no idling
    task automatic test_good_frames();
        idle_on = 1'b0;
        send_frame(KIND_GOOD, 1'b1, 1'b1, 8'hFF);
        send_frame(KIND_GOOD, 1'b0, 1'b1, 8'h00);
        send_frame(KIND_GOOD, 1'b1, 1'b1, 8'h00);
        send_frame(KIND_GOOD, 1'b0, 1'b1, 8'hFF);
        idle_on = 1'b1;
    endtask

    // header hunting: repeated first byte, other byte after it, lone second byte
    task automatic test_header_hunt();
        send_byte(sfd_pkg::HDR_SECOND);
        send_byte(sfd_pkg::HDR_FIRST);
        send_byte(sfd_pkg::HDR_FIRST);
        send_frame(KIND_GOOD, 1'b0, 1'b0, 8'h00);
        // the byte after the first header byte is dropped, not retried
        send_byte(sfd_pkg::HDR_FIRST);
        send_byte(8'h12);
        send_byte(sfd_pkg::HDR_SECOND);
        send_byte(sfd_pkg::TYPE_PERC);
        send_byte(sfd_pkg::HDR_FIRST);
        send_byte(8'h00);
        send_frame(KIND_GOOD, 1'b1, 1'b0, 8'h00);
    endtask

    // unknown type on the long frame, bad tail and bad crc on both frame lengths
    task automatic test_rejects();
        send_frame(KIND_BAD_TYPE, 1'b1, 1'b0, 8'h00);
        send_frame(KIND_BAD_TAIL, 1'b1, 1'b0, 8'h00);
        send_frame(KIND_BAD_TAIL, 1'b0, 1'b0, 8'h00);
        send_frame(KIND_BAD_CRC,  1'b1, 1'b0, 8'h00);
        send_frame(KIND_BAD_CRC,  1'b0, 1'b0, 8'h00);
        send_frame(KIND_GOOD,     1'b0, 1'b0, 8'h00);
    endtask

    // long receiver hold-off while frames keep coming, so the input stalls
    task automatic test_backpressure();
        wait_for_drain();
        idle_on   = 1'b0;
        hold_left = 400;
        for (int i = 0; i < 8; i++)
            send_frame(KIND_GOOD, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
        wait_for_drain();
        idle_on = 1'b1;
    endtask

    // sender pauses until all owed results are out, then resumes
    task automatic test_drain_pause();
        send_frame(KIND_GOOD, 1'b1, 1'b0, 8'h00);
        send_frame(KIND_BAD_CRC, 1'b0, 1'b0, 8'h00);
        wait_for_drain();
        send_frame(KIND_GOOD, 1'b0, 1'b0, 8'h00);
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic test_random_traffic();
        int unsigned start_bytes;
        int unsigned pick;
        start_bytes = frame_bytes_sent;
        while ((frame_bytes_sent - start_bytes) < 470)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
                send_byte(sfd_pkg::HDR_FIRST);
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_frame(KIND_GOOD, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
            else if (pick < 65)
                send_frame(KIND_BAD_TAIL, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
            else if (pick < 75)
                send_frame(KIND_BAD_CRC, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
            else if (pick < 82)
                send_frame(KIND_BAD_TYPE, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
            else if (pick < 90)
                send_frame(KIND_CUT, ($urandom_range(0, 1) == 1), 1'b0, 8'h00);
            else
                send_noise($urandom_range(1, 12));
            if ($urandom_range(0, 15) == 0)
                wait_for_drain();
        end
        idle_on = 1'b1;
    endtask

    // reset, the tests in turn, then drain and verdict
    initial
    begin
        deframer_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_good_frames();
        test_header_hunt();
        test_rejects();
        test_backpressure();
        test_drain_pause();
        test_random_traffic();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frames_due.size() != 0)
            report_issue($sformatf("%0d frame results never arrived", frames_due.size()));
        $display("covered %0d bytes in, %0d frame results checked (%0d good, %0d rejected)",
                 bytes_sent, frames_checked, good_checked, bad_checked);
        $display("header hunting, unknown types, bad tails and crcs, cut frames, stalls");
        if (mismatches == 0)
            $display("serial_frame_deframer_crc16_test: PASS");
        else
            $display("serial_frame_deframer_crc16_test: FAIL");
        $finish;
    end

endmodule
